// File: rtl/imab_pkg.sv
// ----------------------------------------------------------------------------
// imab_pkg
// Shared types, header codes and the step table of the mono ADPCM decoder.
// ----------------------------------------------------------------------------
package imab_pkg;

    // input beat: one byte of the encoded block
    typedef struct packed {
        logic [7:0] byte_value;
        logic       block_start;
    } in_beat_t;

    // output beat: one decoded sample
    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_in_block;
    } out_beat_t;

    // decoder state carried from one code to the next
    typedef struct packed {
        logic signed [15:0] predictor;
        logic [7:0]         step_index;
        logic [14:0]        step_size;
    } dec_state_t;

    localparam int POS_W = 12;
    localparam int CFG_W = 13;

    // byte positions inside the block header
    localparam logic [POS_W-1:0] POS_PRED_LO  = 12'd0;
    localparam logic [POS_W-1:0] POS_PRED_HI  = 12'd1;
    localparam logic [POS_W-1:0] POS_STEP_IDX = 12'd2;
    localparam logic [POS_W-1:0] POS_RESERVED = 12'd3;
    localparam logic [POS_W-1:0] POS_FIRST_DATA = 12'd4;
    localparam logic [POS_W-1:0] POS_MAX      = 12'd4095;

    localparam logic [7:0]         IDX_MAX    = 8'd88;
    localparam logic signed [17:0] SAMPLE_MAX = 18'sd32767;
    localparam logic signed [17:0] SAMPLE_MIN = -18'sd32768;

    localparam logic [CFG_W-1:0] BLOCK_SAMPLES_RST = 13'd1016;
    localparam logic [14:0]      STEP_SIZE_RST     = 15'd7;

    // step table, entries past 88 are zero
    function automatic logic [14:0] step_lookup(input logic [6:0] idx);
        logic [14:0] s;
        case (idx)
            7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
            7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
            7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
            7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
            7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
            7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
            7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
            7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
            7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
            7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
            7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
            7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
            7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
            7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
            7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
            7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
            7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
            7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
            7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
            7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
            7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
            7'd87: s = 15'd29794; 7'd88: s = 15'd32767;
            default: s = 15'd0;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/ima_adpcm_mono_block_decoder.sv
// ----------------------------------------------------------------------------
// ima_adpcm_mono_block_decoder
// Byte-stream decoder for mono 4-bit IMA ADPCM blocks.
// ----------------------------------------------------------------------------
// Header bytes (predictor low, predictor high, step index, reserved) take a
// decode step of their own each; a data byte takes a step per nibble, since both codes
// go through the same combinational decode step and each sample depends on the
// one before it. Samples leave one per cycle through an output register while
// m_ready stays high; a step waits while that register is full. A new byte is
// taken in the cycle the held one finishes. block_samples may be rewritten at
// any time between blocks and takes effect immediately.
module ima_adpcm_mono_block_decoder #(
    parameter int MAX_BLOCK_SAMPLES = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  imab_pkg::in_beat_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output imab_pkg::out_beat_t  m_data,
    input  logic                 cfg_wr_en,
    input  logic [imab_pkg::CFG_W-1:0] cfg_wr_data
);

    localparam int DONE_W = $clog2(MAX_BLOCK_SAMPLES + 1);
    localparam int CNT_W  = (DONE_W > imab_pkg::CFG_W) ? DONE_W : imab_pkg::CFG_W;

    logic [imab_pkg::CFG_W-1:0] block_samples_reg;

    // held input byte
    logic       hold_valid_reg;
    logic [7:0] hold_byte_reg;
    logic       hold_start_reg;
    logic       half_reg;

    imab_pkg::dec_state_t st_reg, st_next, dec_out;
    logic [imab_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [DONE_W-1:0]          done_reg, done_next;

    logic                 m_valid_reg;
    imab_pkg::out_beat_t  m_data_reg, m_data_next;

    logic [imab_pkg::POS_W-1:0] eff_pos;
    logic [DONE_W-1:0]          eff_done;
    logic [CNT_W-1:0]           target;
    logic [CNT_W-1:0]           bs_ext;
    logic [CNT_W-1:0]           done_inc;
    logic                       is_data;
    logic                       emit;
    logic                       out_free;
    logic                       step_en;
    logic                       byte_done;
    logic                       accept_in;
    logic [3:0]                 code;

    assign bs_ext = CNT_W'(block_samples_reg);
    assign target = (bs_ext > CNT_W'(MAX_BLOCK_SAMPLES)) ? CNT_W'(MAX_BLOCK_SAMPLES) : bs_ext;

    // block_start restarts position and sample count for the held byte
    assign eff_pos  = hold_start_reg ? '0 : pos_reg;
    assign eff_done = hold_start_reg ? '0 : done_reg;
    assign done_inc = CNT_W'(eff_done) + CNT_W'(1);

    assign is_data  = (eff_pos >= imab_pkg::POS_FIRST_DATA);
    assign emit     = is_data && (CNT_W'(eff_done) < target);
    assign out_free = !m_valid_reg || m_ready;
    assign step_en  = hold_valid_reg && out_free;
    assign byte_done = step_en && (!is_data || half_reg);
    assign s_ready   = !hold_valid_reg || byte_done;
    assign accept_in = s_valid && s_ready;

    assign code = half_reg ? hold_byte_reg[7:4] : hold_byte_reg[3:0];

    imab_decode u_decode (
        .code (code),
        .cur  (st_reg),
        .nxt  (dec_out)
    );

    always_comb begin
        st_next   = st_reg;
        done_next = eff_done;
        pos_next  = pos_reg;
        m_data_next.sample        = dec_out.predictor;
        m_data_next.last_in_block = (done_inc == target);
        case (eff_pos)
            imab_pkg::POS_PRED_LO: begin
                st_next.predictor[7:0] = hold_byte_reg;
            end
            imab_pkg::POS_PRED_HI: begin
                st_next.predictor[15:8] = hold_byte_reg;
            end
            imab_pkg::POS_STEP_IDX: begin
                st_next.step_index = hold_byte_reg;
                st_next.step_size  = imab_pkg::step_lookup(hold_byte_reg[6:0]);
            end
            imab_pkg::POS_RESERVED: begin
            end
            default: begin
                if (emit) begin
                    st_next   = dec_out;
                    done_next = done_inc[DONE_W-1:0];
                end
            end
        endcase
        if (byte_done) begin
            pos_next = (eff_pos < imab_pkg::POS_MAX) ? eff_pos + 1'b1 : eff_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_samples_reg <= imab_pkg::BLOCK_SAMPLES_RST;
            hold_valid_reg    <= 1'b0;
            hold_start_reg    <= 1'b0;
            half_reg          <= 1'b0;
            st_reg.predictor  <= '0;
            st_reg.step_index <= '0;
            st_reg.step_size  <= imab_pkg::STEP_SIZE_RST;
            pos_reg           <= '0;
            done_reg          <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                block_samples_reg <= cfg_wr_data;
            end
            if (accept_in) begin
                hold_valid_reg <= 1'b1;
                hold_start_reg <= s_data.block_start;
            end else if (byte_done) begin
                hold_valid_reg <= 1'b0;
            end
            if (step_en) begin
                half_reg <= is_data && !half_reg;
                st_reg   <= st_next;
                pos_reg  <= pos_next;
                done_reg <= done_next;
            end
            if (step_en && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept_in) begin
            hold_byte_reg <= s_data.byte_value;
        end
        if (step_en && emit) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/imab_decode.sv
// ----------------------------------------------------------------------------
// imab_decode
// One 4-bit code: index adjust and clamp, difference, saturated predictor.
// ----------------------------------------------------------------------------
module imab_decode (
    input  logic [3:0]          code,
    input  imab_pkg::dec_state_t cur,
    output imab_pkg::dec_state_t nxt
);

    logic [2:0]         mag;
    logic signed [4:0]  adj;
    logic signed [9:0]  idx_sum;
    logic [7:0]         idx_clamped;
    logic [3:0]         odd;
    logic [18:0]        prod;
    logic [15:0]        diff;
    logic signed [17:0] pred_sum;
    logic signed [15:0] pred_sat;

    assign mag = code[2:0];

    // magnitudes 0..3 step down by one, 4..7 step up by 2,4,6,8
    assign adj = mag[2] ? $signed({1'b0, ({1'b0, mag[1:0]} + 3'd1), 1'b0}) : -5'sd1;
    assign idx_sum = $signed({2'b00, cur.step_index}) + 10'(adj);

    always_comb begin
        if (idx_sum < 10'sd0) begin
            idx_clamped = 8'd0;
        end else if (idx_sum > $signed({2'b00, imab_pkg::IDX_MAX})) begin
            idx_clamped = imab_pkg::IDX_MAX;
        end else begin
            idx_clamped = idx_sum[7:0];
        end
    end

    assign odd  = {mag, 1'b1};
    assign prod = {4'b0000, cur.step_size} * {15'd0, odd};
    assign diff = prod[18:3];

    always_comb begin
        if (code[3]) begin
            pred_sum = 18'(cur.predictor) - $signed({2'b00, diff});
        end else begin
            pred_sum = 18'(cur.predictor) + $signed({2'b00, diff});
        end
        if (pred_sum > imab_pkg::SAMPLE_MAX) begin
            pred_sat = imab_pkg::SAMPLE_MAX[15:0];
        end else if (pred_sum < imab_pkg::SAMPLE_MIN) begin
            pred_sat = imab_pkg::SAMPLE_MIN[15:0];
        end else begin
            pred_sat = pred_sum[15:0];
        end
    end

    assign nxt.predictor  = pred_sat;
    assign nxt.step_index = idx_clamped;
    assign nxt.step_size  = imab_pkg::step_lookup(idx_clamped[6:0]);

endmodule
